@@ hw/rtl/lsc_pkg.sv @@
// ============================================================================
// lsc_pkg
// Shared constants, register indexes and saturation helper for the LQR
// steering controller.
// ============================================================================
package lsc_pkg;

    localparam int ONE_Q16    = 65536;
    localparam int MIN_SPEED  = 19661;
    localparam int SAT_SPEED  = 655360;
    localparam int TS_BASE    = 29491;
    localparam int SPEED_DIV  = 60;
    localparam int A_ROW2_X0  = -14824;
    localparam int A_ROW2_X1  = 79837;
    localparam int B_FIRST    = -824662;
    localparam int B_SECOND   = 169910;

    // Speed over sixty as a reciprocal product: (speed * SPEED_RECIP) >> 29
    // is exact for every 23-bit speed.
    localparam int SPEED_RECIP    = 8947849;
    localparam int SPEED_RECIP_SH = 29;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FB_GAIN_FIRST  = 3'd0,
        CFG_FB_GAIN_SECOND = 3'd1,
        CFG_OBS_GAIN_FIRST = 3'd2,
        CFG_OBS_GAIN_SECOND = 3'd3,
        CFG_INV_DC_GAIN    = 3'd4,
        CFG_OUT_SCALE_RECIP = 3'd5,
        CFG_INTEGRAL_GAIN  = 3'd6,
        CFG_SAT_TIME_LIMIT = 3'd7
    } t_cfg_idx;

    // Saturate a wide signed value to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [55:0] x);
        logic signed [31:0] r;
        if (x > 56'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -56'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/lqr_steer_controller_top.sv @@
// ============================================================================
// lqr_steer_controller_top
// LQR steering controller with a two-state observer, integrator with
// anti-windup, output clamp and leaky saturation timer, Q16.16 throughout.
// ============================================================================
// Usage: one control tick enters as a word on the input channel (i_valid /
// o_ready) and one result word leaves on the output channel (o_valid /
// i_ready). The block works on one tick at a time: o_ready is high only while
// the sequencer is idle. A tick first divides the speed by sixty as a
// reciprocal product, squares the torque scale, divides the torque by it in
// a restoring divider, then runs the remaining products through a single
// 35 x 33 bit multiplier, one product at a time. An inactive tick skips the
// feedback and integrator products and an overridden one skips the integrator
// products; the next tick is taken only once the sequencer is idle again.
// The result sits in an output register; a new tick may be accepted while it
// waits. If the receiver still stalls when the next tick is finished, the
// sequencer holds in its final step until the register is free.
// Configuration registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data with no wait state and should only change while idle.
// A synchronous reset loads the register defaults, clears the observer,
// integrator and timer, and empties the output register.
// ============================================================================
module lqr_steer_controller_top #(
    parameter int TICK_Q16 = 655
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_enable,
    input  logic [22:0]                      i_speed,
    input  logic signed [24:0]               i_measured_angle,
    input  logic signed [31:0]               i_motor_torque,
    input  logic                             i_driver_override,
    input  logic                             i_rate_limited,
    input  logic signed [24:0]               i_target_angle,
    input  logic signed [24:0]               i_angle_offset,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [17:0]               o_steer_command,
    output logic                             o_saturated,
    output logic                             o_loop_active,
    output logic signed [31:0]               o_estimated_angle,
    output logic signed [31:0]               o_integrator_value,
    output logic signed [31:0]               o_feedback_part
);
    import lsc_pkg::*;

    localparam logic [17:0]        TICK   = 18'(TICK_Q16);
    localparam logic signed [31:0] UNWIND = 32'(TICK_Q16 * 3 / 10);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_ACC, S_FIN} t_state;
    typedef enum logic [3:0] {
        OP_SD, OP_TT, OP_B1, OP_L1, OP_A0, OP_A1, OP_B2, OP_L2,
        OP_FF, OP_K1, OP_K2, OP_P, OP_S, OP_KT, OP_KE
    } t_op;

    t_state r_state;
    t_op    r_op;

    // Configuration registers.
    logic signed [31:0] r_fg1, r_fg2, r_og1, r_og2, r_idg;
    logic [31:0]        r_recip;
    logic [16:0]        r_ig, r_lim;

    // Latched tick.
    logic               r_enable, r_ovr, r_rlim;
    logic [22:0]        r_speed;
    logic signed [24:0] r_meas, r_target, r_offset;
    logic signed [31:0] r_torque;

    // Divider.
    logic [47:0] r_dvd, r_quo;
    logic [18:0] r_rem, r_dvsr;
    logic [5:0]  r_cnt;

    // Datapath.
    logic [17:0]        r_t;
    logic [18:0]        r_ts;
    logic signed [34:0] r_ut;
    logic signed [67:0] r_prod;
    logic signed [55:0] r_acc;
    logic signed [31:0] r_nf, r_ns, r_tmp, r_lqr;
    logic [32:0]        r_kt;
    logic signed [33:0] r_istep;

    // Controller state.
    logic signed [31:0] r_est_first, r_est_second, r_integ;
    logic [16:0]        r_timer;

    // Output register.
    logic               r_o_valid, r_o_sat, r_o_act;
    logic signed [17:0] r_o_cmd;
    logic signed [31:0] r_o_est, r_o_integ, r_o_fb;

    // Combinational helpers.
    logic signed [25:0] w_des;
    logic signed [32:0] w_e33, w_err33;
    logic signed [31:0] w_e, w_err;
    logic               w_active;
    logic [16:0]        w_ki;
    logic [31:0]        w_tmag;
    logic signed [34:0] w_a;
    logic signed [32:0] w_b;
    logic signed [55:0] w_sh16, w_sh32, w_p56;
    logic [19:0]        w_rem_sh;
    logic               w_ge;
    logic [19:0]        w_rem_sub;
    logic signed [31:0] w_inew, w_integ_nx;
    logic signed [33:0] w_ctl, w_cmd34;
    logic signed [17:0] w_cmd;
    logic               w_upd, w_check, w_satnow;
    logic [16:0]        w_tbase, w_timer_nx;
    logic [17:0]        w_tsum;

    assign w_des   = {r_target[24], r_target} - {r_offset[24], r_offset};
    // The innovation compares the offset-corrected measurement with the estimate.
    assign w_e33   = 33'(r_meas) - 33'(r_offset) - 33'(r_est_first);
    assign w_e     = sat32(56'(w_e33));
    assign w_err33 = 33'(w_des) - 33'(r_est_first);
    assign w_err   = sat32(56'(w_err33));
    assign w_active = r_enable && (r_speed >= 23'(MIN_SPEED));
    assign w_ki    = (r_ig > 17'(ONE_Q16)) ? 17'(ONE_Q16) : r_ig;
    assign w_tmag  = r_torque[31] ? 32'(-r_torque) : 32'(r_torque);

    // Operand selection for the shared multiplier.
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_op)
            OP_SD: begin
                w_a = {12'b0, r_speed};
                w_b = 33'(SPEED_RECIP);
            end
            OP_TT: begin
                w_a = {17'b0, r_t};
                w_b = {15'b0, r_t};
            end
            OP_B1: begin
                w_a = r_ut;
                w_b = 33'(B_FIRST);
            end
            OP_L1: begin
                w_a = 35'(w_e);
                w_b = 33'(r_og1);
            end
            OP_A0: begin
                w_a = 35'(r_est_first);
                w_b = 33'(A_ROW2_X0);
            end
            OP_A1: begin
                w_a = 35'(r_est_second);
                w_b = 33'(A_ROW2_X1);
            end
            OP_B2: begin
                w_a = r_ut;
                w_b = 33'(B_SECOND);
            end
            OP_L2: begin
                w_a = 35'(w_e);
                w_b = 33'(r_og2);
            end
            OP_FF: begin
                w_a = 35'(w_des);
                w_b = 33'(r_idg);
            end
            OP_K1: begin
                w_a = 35'(r_nf);
                w_b = 33'(r_fg1);
            end
            OP_K2: begin
                w_a = 35'(r_ns);
                w_b = 33'(r_fg2);
            end
            OP_P: begin
                w_a = 35'(r_tmp);
                w_b = {14'b0, r_ts};
            end
            OP_S: begin
                w_a = 35'(r_tmp);
                w_b = {1'b0, r_recip};
            end
            OP_KT: begin
                w_a = {18'b0, w_ki};
                w_b = {15'b0, TICK};
            end
            OP_KE: begin
                w_a = {2'b0, r_kt};
                w_b = 33'(w_err);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_sh16 = 56'(r_prod >>> 16);
    assign w_sh32 = 56'(r_prod >>> 32);
    assign w_p56  = 56'(r_prod);

    // One restoring division step.
    assign w_rem_sh  = {r_rem, r_dvd[47]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_dvsr});
    assign w_rem_sub = w_rem_sh - {1'b0, r_dvsr};

    // Integrator, clamp and timer for the final step.
    assign w_inew = sat32(56'(r_integ) + 56'(r_istep));
    assign w_ctl  = 34'(r_lqr) + 34'(w_inew);
    assign w_upd  = (!w_err33[32] && (w_ctl <= 34'sd65536 || w_inew < 0)) ||
                    ((w_err33[32] || w_err33 == 0) && (w_ctl >= -34'sd65536 || w_inew > 0));

    always_comb begin
        if (!w_active) begin
            w_integ_nx = '0;
        end else if (r_ovr) begin
            if (r_integ > 0) begin
                w_integ_nx = r_integ - UNWIND;
            end else if (r_integ < 0) begin
                w_integ_nx = r_integ + UNWIND;
            end else begin
                w_integ_nx = r_integ;
            end
        end else begin
            w_integ_nx = w_upd ? w_inew : r_integ;
        end
    end

    assign w_cmd34 = 34'(r_lqr) + 34'(w_integ_nx);

    always_comb begin
        if (!w_active) begin
            w_cmd = '0;
        end else if (w_cmd34 > 34'sd65536) begin
            w_cmd = 18'sd65536;
        end else if (w_cmd34 < -34'sd65536) begin
            w_cmd = -18'sd65536;
        end else begin
            w_cmd = w_cmd34[17:0];
        end
    end

    assign w_check  = (r_speed > 23'(SAT_SPEED)) && !r_rlim && !r_ovr;
    assign w_satnow = (w_cmd == 18'sd65536) || (w_cmd == -18'sd65536);
    assign w_tbase  = w_active ? r_timer : 17'd0;
    assign w_tsum   = {1'b0, w_tbase} + TICK;

    always_comb begin
        if (w_satnow && w_check) begin
            w_timer_nx = (w_tsum > 18'(ONE_Q16)) ? 17'(ONE_Q16) : w_tsum[16:0];
        end else if ({1'b0, w_tbase} < TICK) begin
            w_timer_nx = '0;
        end else begin
            w_timer_nx = 17'({1'b0, w_tbase} - TICK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_op         <= OP_TT;
            r_fg1        <= -32'sd7257176;
            r_fg2        <= 32'sd29571625;
            r_og1        <= 32'sd21192;
            r_og2        <= 32'sd20878;
            r_idg        <= 32'sd29285220;
            r_recip      <= 32'd2863311;
            r_ig         <= 17'd3277;
            r_lim        <= 17'd26214;
            r_est_first  <= '0;
            r_est_second <= '0;
            r_integ      <= '0;
            r_timer      <= '0;
            r_o_valid    <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_FB_GAIN_FIRST:   r_fg1   <= i_cfg_data;
                    CFG_FB_GAIN_SECOND:  r_fg2   <= i_cfg_data;
                    CFG_OBS_GAIN_FIRST:  r_og1   <= i_cfg_data;
                    CFG_OBS_GAIN_SECOND: r_og2   <= i_cfg_data;
                    CFG_INV_DC_GAIN:     r_idg   <= i_cfg_data;
                    CFG_OUT_SCALE_RECIP: r_recip <= i_cfg_data;
                    CFG_INTEGRAL_GAIN:   r_ig    <= i_cfg_data[16:0];
                    CFG_SAT_TIME_LIMIT:  r_lim   <= i_cfg_data[16:0];
                    default: ;
                endcase
            end

            // The final step refills the register itself when it is free.
            if (r_o_valid && i_ready && r_state != S_FIN) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_enable <= i_enable;
                        r_speed  <= i_speed;
                        r_meas   <= i_measured_angle;
                        r_torque <= i_motor_torque;
                        r_ovr    <= i_driver_override;
                        r_rlim   <= i_rate_limited;
                        r_target <= i_target_angle;
                        r_offset <= i_angle_offset;
                        r_lqr    <= '0;
                        r_op     <= OP_SD;
                        r_state  <= S_MUL;
                    end
                end
                S_DIV: begin
                    if (r_cnt != 0) begin
                        r_rem <= w_ge ? w_rem_sub[18:0] : w_rem_sh[18:0];
                        r_quo <= {r_quo[46:0], w_ge};
                        r_dvd <= {r_dvd[46:0], 1'b0};
                        r_cnt <= r_cnt - 6'd1;
                    end else begin
                        r_ut    <= r_torque[31] ? -$signed({1'b0, r_quo[33:0]})
                                                : $signed({1'b0, r_quo[33:0]});
                        r_op    <= OP_B1;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_a * w_b;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    case (r_op)
                        OP_SD: begin
                            r_t     <= 18'(TS_BASE) + r_prod[SPEED_RECIP_SH +: 18];
                            r_op    <= OP_TT;
                            r_state <= S_MUL;
                        end
                        OP_TT: begin
                            r_ts     <= r_prod[34:16];
                            r_dvsr   <= r_prod[34:16];
                            r_dvd    <= {w_tmag, 16'b0};
                            r_rem    <= '0;
                            r_quo    <= '0;
                            r_cnt    <= 6'd48;
                            r_state  <= S_DIV;
                        end
                        OP_B1: begin
                            r_acc   <= 56'(r_est_second) + w_sh32;
                            r_op    <= OP_L1;
                            r_state <= S_MUL;
                        end
                        OP_L1: begin
                            r_nf    <= sat32(r_acc + w_sh16);
                            r_op    <= OP_A0;
                            r_state <= S_MUL;
                        end
                        OP_A0: begin
                            r_acc   <= w_p56;
                            r_op    <= OP_A1;
                            r_state <= S_MUL;
                        end
                        OP_A1: begin
                            r_acc   <= (r_acc + w_p56) >>> 16;
                            r_op    <= OP_B2;
                            r_state <= S_MUL;
                        end
                        OP_B2: begin
                            r_acc   <= r_acc + w_sh32;
                            r_op    <= OP_L2;
                            r_state <= S_MUL;
                        end
                        OP_L2: begin
                            r_ns <= sat32(r_acc + w_sh16);
                            r_op <= OP_FF;
                            r_state <= w_active ? S_MUL : S_FIN;
                        end
                        OP_FF: begin
                            r_acc   <= w_sh16;
                            r_op    <= OP_K1;
                            r_state <= S_MUL;
                        end
                        OP_K1: begin
                            r_acc   <= r_acc - w_sh16;
                            r_op    <= OP_K2;
                            r_state <= S_MUL;
                        end
                        OP_K2: begin
                            r_tmp   <= sat32(r_acc - w_sh16);
                            r_op    <= OP_P;
                            r_state <= S_MUL;
                        end
                        OP_P: begin
                            r_tmp   <= sat32(w_sh16);
                            r_op    <= OP_S;
                            r_state <= S_MUL;
                        end
                        OP_S: begin
                            r_lqr   <= sat32(w_sh32);
                            r_op    <= OP_KT;
                            r_state <= r_ovr ? S_FIN : S_MUL;
                        end
                        OP_KT: begin
                            r_kt    <= r_prod[32:0];
                            r_op    <= OP_KE;
                            r_state <= S_MUL;
                        end
                        OP_KE: begin
                            r_istep <= 34'(r_prod >>> 32);
                            r_state <= S_FIN;
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_FIN: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid    <= 1'b1;
                        r_o_cmd      <= w_cmd;
                        r_o_sat      <= (w_timer_nx > r_lim);
                        r_o_act      <= w_active;
                        r_o_est      <= sat32(56'(r_est_first) + 56'(r_offset));
                        r_o_integ    <= w_integ_nx;
                        r_o_fb       <= r_lqr;
                        r_est_first  <= r_nf;
                        r_est_second <= r_ns;
                        r_integ      <= w_integ_nx;
                        r_timer      <= w_timer_nx;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = r_o_valid;
    assign o_steer_command    = r_o_cmd;
    assign o_saturated        = r_o_sat;
    assign o_loop_active      = r_o_act;
    assign o_estimated_angle  = r_o_est;
    assign o_integrator_value = r_o_integ;
    assign o_feedback_part    = r_o_fb;

    // The saturation timer is cleared whenever the loop is not active.
    a_sat_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_loop_active)
        else $error("saturated flag raised with the loop inactive");

    // An inactive tick gives a zero command and no feedback term.
    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_loop_active |-> o_steer_command == 0 && o_feedback_part == 0)
        else $error("inactive tick produced a nonzero command");

    // The command never leaves plus or minus one.
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_steer_command <= 18'sd65536 && o_steer_command >= -18'sd65536)
        else $error("steer command outside the clamp");

    // A finished word is never overwritten before it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_feedback_part))
        else $error("result word lost while stalled");

endmodule
